### sv/lhm_pkg.sv
// Shared types and constants for the latency histogram monitor.
// Depends on nothing; RTL uses scoped names, the testbench imports it.
package lhm_pkg;

    // Default configuration of the monitor
    localparam int OPS_DEFAULT           = 16;
    localparam int BUCKETS_DEFAULT       = 16;
    localparam int BUCKET_CYCLES_DEFAULT = 100;

    // Saturation value of a latency, also the reset value of a minimum
    localparam logic [31:0] LAT_SAT = 32'hFFFF_FFFF;

    // Operation codes carried by the mode field
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_END    = 3'd1,
        MODE_RECORD = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    // Histogram request from the slot stage to the histogram stage
    typedef struct packed {
        logic rd;   // read-mode beat wants the selected bucket
        logic inc;  // sample lands in an in-range bucket
        logic clr;  // wipe all buckets of the slot
    } hist_ctl_t;

    // Per-beat result of the slot stage
    typedef struct packed {
        logic        status;
        logic [31:0] samples;
        logic [63:0] total;
        logic [31:0] lat_min;
        logic [31:0] lat_max;
        logic [31:0] beyond;
    } stats_t;

endpackage

### sv/latency_histogram_monitor.sv
// Latency histogram monitor: one beat in, one result beat out per cycle while
// out_ready keeps it moving. A beat passes the input, histogram-stage and
// output registers in turn; the RAM bypass takes back-to-back beats.
// Reset clears all statistics and pending marks (minima to all ones) at once
// through flops and bucket valid bits; no clearing pass, enable resets to 1.
// Depends on lhm_pkg, lhm_stats, lhm_hist and lhm_ram.
module latency_histogram_monitor #(
    parameter int OPS           = lhm_pkg::OPS_DEFAULT,
    parameter int BUCKETS       = lhm_pkg::BUCKETS_DEFAULT,
    parameter int BUCKET_CYCLES = lhm_pkg::BUCKET_CYCLES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [3:0]  op_slot,
    input  logic [63:0] time_stamp,
    input  logic [31:0] latency_in,
    input  logic [3:0]  bucket_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [31:0] sample_count,
    output logic [63:0] cycle_total,
    output logic [31:0] latency_min,
    output logic [31:0] latency_max,
    output logic [31:0] overflow_count,
    output logic [31:0] bucket_count
);

    localparam int SLOT_W = (OPS > 1) ? $clog2(OPS) : 1;
    localparam int BKT_W  = $clog2(BUCKETS);

    logic        enable_reg;
    logic        adv;
    logic        fire;

    logic        s1_valid_reg;
    logic [2:0]  s1_mode_reg;
    logic [3:0]  s1_slot_reg;
    logic [63:0] s1_ts_reg;
    logic [31:0] s1_lat_reg;
    logic [3:0]  s1_sel_reg;

    logic            s2_valid_reg;
    lhm_pkg::stats_t s2_stats_reg;

    logic            out_valid_reg;
    lhm_pkg::stats_t out_stats_reg;
    logic [31:0]     out_bucket_reg;

    lhm_pkg::stats_t    stats;
    lhm_pkg::hist_ctl_t hist_ctl;
    logic [SLOT_W-1:0]  hist_slot;
    logic [BKT_W-1:0]   hist_bucket;
    logic [31:0]        hist_count;

    // Whole pipeline moves when the output register is free or drained
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign fire     = adv && s1_valid_reg;

    // Enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_data;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg    <= mode;
            s1_slot_reg    <= op_slot;
            s1_ts_reg      <= time_stamp;
            s1_lat_reg     <= latency_in;
            s1_sel_reg     <= bucket_select;
            s2_stats_reg   <= stats;
            out_stats_reg  <= s2_stats_reg;
            out_bucket_reg <= hist_count;
        end
    end

    lhm_stats #(
        .OPS           (OPS),
        .BUCKETS       (BUCKETS),
        .BUCKET_CYCLES (BUCKET_CYCLES)
    ) u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .enable        (enable_reg),
        .mode          (s1_mode_reg),
        .op_slot       (s1_slot_reg),
        .time_stamp    (s1_ts_reg),
        .latency_in    (s1_lat_reg),
        .bucket_select (s1_sel_reg),
        .stats         (stats),
        .hist_ctl      (hist_ctl),
        .hist_slot     (hist_slot),
        .hist_bucket   (hist_bucket)
    );

    lhm_hist #(
        .OPS     (OPS),
        .BUCKETS (BUCKETS)
    ) u_hist (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .issue        (fire),
        .ctl          (hist_ctl),
        .slot         (hist_slot),
        .bucket       (hist_bucket),
        .bucket_count (hist_count)
    );

    // Output beat
    assign out_valid      = out_valid_reg;
    assign status         = out_stats_reg.status;
    assign sample_count   = out_stats_reg.samples;
    assign cycle_total    = out_stats_reg.total;
    assign latency_min    = out_stats_reg.lat_min;
    assign latency_max    = out_stats_reg.lat_max;
    assign overflow_count = out_stats_reg.beyond;
    assign bucket_count   = out_bucket_reg;

    // An ignored beat carries no statistics
    a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> sample_count == 32'd0 && cycle_total == 64'd0
                              && bucket_count == 32'd0)
        else $error("ignored beat carries statistics");

    // An accepted beat enters the slot stage
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted beat lost before slot stage");

    // A beat in the slot stage moves to the histogram stage when advancing
    a_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && adv |=> s2_valid_reg)
        else $error("beat lost between stages");

endmodule

### sv/lhm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lhm_stats.sv
// Slot stage: pending marks, start stamps and per-slot statistics in flops,
// latency and bucket computation. Depends on lhm_pkg.
module lhm_stats #(
    parameter int OPS           = lhm_pkg::OPS_DEFAULT,
    parameter int BUCKETS       = lhm_pkg::BUCKETS_DEFAULT,
    parameter int BUCKET_CYCLES = lhm_pkg::BUCKET_CYCLES_DEFAULT,
    localparam int SLOT_W = (OPS > 1) ? $clog2(OPS) : 1,
    localparam int BKT_W  = $clog2(BUCKETS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               enable,
    input  logic [2:0]         mode,
    input  logic [3:0]         op_slot,
    input  logic [63:0]        time_stamp,
    input  logic [31:0]        latency_in,
    input  logic [3:0]         bucket_select,
    output lhm_pkg::stats_t    stats,
    output lhm_pkg::hist_ctl_t hist_ctl,
    output logic [SLOT_W-1:0]  hist_slot,
    output logic [BKT_W-1:0]   hist_bucket
);

    logic [63:0]     stamp_reg   [OPS];
    logic [31:0]     samples_reg [OPS];
    logic [63:0]     total_reg   [OPS];
    logic [31:0]     min_reg     [OPS];
    logic [31:0]     max_reg     [OPS];
    logic [31:0]     beyond_reg  [OPS];
    logic [OPS-1:0]  pending_reg;
    logic [OPS-1:0]  pending_next;

    logic [SLOT_W-1:0] idx;
    logic              slot_ok;
    logic              sel_ok;
    logic [63:0]       elapsed;
    logic [31:0]       end_lat;
    logic [31:0]       lat;
    logic              do_start, do_end, do_rec, do_clr, do_rd, take;
    logic [BUCKETS:0]  ge;
    logic              overflow;
    logic [BKT_W-1:0]  bucket_idx;

    logic [31:0] samples_next;
    logic [63:0] total_next;
    logic [31:0] min_next;
    logic [31:0] max_next;
    logic [31:0] beyond_next;

    // Slot decode and latency
    always_comb
    begin
        idx     = SLOT_W'(op_slot);
        slot_ok = (32'(op_slot) < 32'(OPS));
        sel_ok  = (32'(bucket_select) < 32'(BUCKETS));
        elapsed = time_stamp - stamp_reg[idx];
        end_lat = (elapsed[63:32] != 32'd0) ? lhm_pkg::LAT_SAT : elapsed[31:0];
    end

    // Mode decode
    always_comb
    begin
        do_start = 1'b0;
        do_end   = 1'b0;
        do_rec   = 1'b0;
        do_clr   = 1'b0;
        do_rd    = 1'b0;
        case (lhm_pkg::mode_t'(mode))
            lhm_pkg::MODE_START:  do_start = enable && slot_ok;
            lhm_pkg::MODE_END:    do_end   = enable && slot_ok && pending_reg[idx];
            lhm_pkg::MODE_RECORD: do_rec   = enable && slot_ok;
            lhm_pkg::MODE_CLEAR:  do_clr   = slot_ok;
            lhm_pkg::MODE_READ:   do_rd    = slot_ok;
            default:              ;
        endcase
        take = do_end || do_rec;
        lat  = do_end ? end_lat : latency_in;
    end

    // Bucket by threshold bank: ge[k] means lat reached bucket k
    always_comb
    begin
        ge[0] = 1'b1;
        for (int k = 1; k <= BUCKETS; k++)
        begin
            ge[k] = (lat >= 32'(k * BUCKET_CYCLES));
        end
        overflow   = ge[BUCKETS];
        bucket_idx = '0;
        for (int k = 0; k < BUCKETS; k++)
        begin
            if (ge[k] && !ge[k+1])
            begin
                bucket_idx = bucket_idx | BKT_W'(k);
            end
        end
    end

    // Next statistics of the addressed slot
    always_comb
    begin
        samples_next = samples_reg[idx];
        total_next   = total_reg[idx];
        min_next     = min_reg[idx];
        max_next     = max_reg[idx];
        beyond_next  = beyond_reg[idx];
        if (do_clr)
        begin
            samples_next = '0;
            total_next   = '0;
            min_next     = lhm_pkg::LAT_SAT;
            max_next     = '0;
            beyond_next  = '0;
        end
        else if (take)
        begin
            samples_next = samples_reg[idx] + 32'd1;
            total_next   = total_reg[idx] + {32'd0, lat};
            if (lat < min_reg[idx])
            begin
                min_next = lat;
            end
            if (lat > max_reg[idx])
            begin
                max_next = lat;
            end
            if (overflow)
            begin
                beyond_next = beyond_reg[idx] + 32'd1;
            end
        end

        pending_next = pending_reg;
        if (do_start)
        begin
            pending_next[idx] = 1'b1;
        end
        else if (do_end)
        begin
            pending_next[idx] = 1'b0;
        end
    end

    // Results and histogram request
    always_comb
    begin
        stats.status  = !(do_start || take || do_clr || do_rd);
        stats.samples = do_rd ? samples_reg[idx] : 32'd0;
        stats.total   = do_rd ? total_reg[idx]   : 64'd0;
        stats.lat_min = do_rd ? min_reg[idx]     : 32'd0;
        stats.lat_max = do_rd ? max_reg[idx]     : 32'd0;
        stats.beyond  = do_rd ? beyond_reg[idx]  : 32'd0;

        hist_ctl.rd  = do_rd && sel_ok;
        hist_ctl.inc = take && !overflow;
        hist_ctl.clr = do_clr;
        hist_slot    = idx;
        hist_bucket  = do_rd ? BKT_W'(bucket_select) : bucket_idx;
    end

    // Statistics and pending marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < OPS; s++)
            begin
                samples_reg[s] <= '0;
                total_reg[s]   <= '0;
                min_reg[s]     <= lhm_pkg::LAT_SAT;
                max_reg[s]     <= '0;
                beyond_reg[s]  <= '0;
            end
            pending_reg <= '0;
        end
        else if (fire && slot_ok)
        begin
            samples_reg[idx] <= samples_next;
            total_reg[idx]   <= total_next;
            min_reg[idx]     <= min_next;
            max_reg[idx]     <= max_next;
            beyond_reg[idx]  <= beyond_next;
            pending_reg      <= pending_next;
        end
    end

    // Start stamps, only read behind a pending mark
    always_ff @(posedge clk)
    begin
        if (fire && do_start)
        begin
            stamp_reg[idx] <= time_stamp;
        end
    end

endmodule

### sv/lhm_hist.sv
// Histogram stage: bucket RAM with per-entry valid bits, read-modify-write
// increment with write-to-read bypass. Depends on lhm_pkg and lhm_ram.
module lhm_hist #(
    parameter int OPS     = lhm_pkg::OPS_DEFAULT,
    parameter int BUCKETS = lhm_pkg::BUCKETS_DEFAULT,
    localparam int SLOT_W = (OPS > 1) ? $clog2(OPS) : 1,
    localparam int BKT_W  = $clog2(BUCKETS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               issue,
    input  lhm_pkg::hist_ctl_t ctl,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [BKT_W-1:0]   bucket,
    output logic [31:0]        bucket_count
);

    localparam int DEPTH  = OPS * BUCKETS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic              s2_rd_reg;
    logic              s2_inc_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic              s2_vld_reg;
    logic              s2_byp_reg;
    logic [31:0]       s2_byp_data_reg;

    logic [ADDR_W-1:0] addr;
    logic              re;
    logic              wr;
    logic [31:0]       rdata;
    logic [31:0]       cur_value;
    logic [31:0]       wdata;
    logic              clr_now;

    // Request address and write-back of the older beat
    always_comb
    begin
        addr      = ADDR_W'(int'(slot) * BUCKETS + int'(bucket));
        re        = issue && (ctl.rd || ctl.inc);
        clr_now   = issue && ctl.clr;
        wr        = adv && s2_inc_reg;
        cur_value = s2_byp_reg ? s2_byp_data_reg : (s2_vld_reg ? rdata : 32'd0);
        wdata     = cur_value + 32'd1;
        bucket_count = s2_rd_reg ? cur_value : 32'd0;
    end

    // Valid bits: a clear of the newer beat wins over the older write
    always_comb
    begin
        valid_next = valid_reg;
        for (int s = 0; s < OPS; s++)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                if (clr_now && (slot == SLOT_W'(s)))
                begin
                    valid_next[s*BUCKETS+b] = 1'b0;
                end
                else if (wr && (s2_addr_reg == ADDR_W'(s*BUCKETS+b)))
                begin
                    valid_next[s*BUCKETS+b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            s2_rd_reg  <= 1'b0;
            s2_inc_reg <= 1'b0;
            s2_byp_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (adv)
            begin
                s2_rd_reg  <= issue && ctl.rd;
                s2_inc_reg <= issue && ctl.inc;
                s2_byp_reg <= wr && (s2_addr_reg == addr);
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_addr_reg     <= addr;
            s2_vld_reg      <= valid_reg[addr];
            s2_byp_data_reg <= wdata;
        end
    end

    lhm_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr),
        .waddr (s2_addr_reg),
        .wdata (wdata),
        .re    (re),
        .raddr (addr),
        .rdata (rdata)
    );

endmodule

### tb/sv/lhm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the latency histogram monitor: watches the config port and both
// beat channels, keeps its own copy of the slot statistics and compares results.
// Depends on lhm_pkg for the mode codes and default sizes.
module lhm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [3:0]  op_slot,
    input  logic [63:0] time_stamp,
    input  logic [31:0] latency_in,
    input  logic [3:0]  bucket_select,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        status,
    input  logic [31:0] sample_count,
    input  logic [63:0] cycle_total,
    input  logic [31:0] latency_min,
    input  logic [31:0] latency_max,
    input  logic [31:0] overflow_count,
    input  logic [31:0] bucket_count,
    output int          fail_count,
    output int          awaiting
);
    import lhm_pkg::*;

    localparam int SLOT_COUNT   = OPS_DEFAULT;
    localparam int BUCKET_COUNT = BUCKETS_DEFAULT;
    localparam int BUCKET_WIDTH = BUCKET_CYCLES_DEFAULT;

    typedef struct packed {
        logic        status;
        logic [31:0] samples;
        logic [63:0] total;
        logic [31:0] lat_min;
        logic [31:0] lat_max;
        logic [31:0] beyond;
        logic [31:0] bucket;
    } slot_report_t;

    // Shadow copy of the monitor state
    logic        enable_q;
    logic [63:0] origin    [SLOT_COUNT];
    logic        armed     [SLOT_COUNT];
    logic [31:0] n_samples [SLOT_COUNT];
    logic [63:0] sum_cyc   [SLOT_COUNT];
    logic [31:0] lo_lat    [SLOT_COUNT];
    logic [31:0] hi_lat    [SLOT_COUNT];
    logic [31:0] spill     [SLOT_COUNT];
    logic [31:0] hist      [SLOT_COUNT][BUCKET_COUNT];

    slot_report_t due_reports [$];
    int           flaw_count = 0;
    int           due_depth  = 0;

    assign fail_count = flaw_count;
    assign awaiting   = due_depth;

    // Statistics of one slot back to their reset values
    function automatic void wipe_slot(input int s);
        n_samples[s] = '0;
        sum_cyc[s]   = '0;
        lo_lat[s]    = LAT_SAT;
        hi_lat[s]    = '0;
        spill[s]     = '0;
        for (int b = 0; b < BUCKET_COUNT; b++)
        begin
            hist[s][b] = '0;
        end
    endfunction

    // Fold one latency sample into a slot
    function automatic void log_sample(input int s, input logic [31:0] lat);
        logic [31:0] bin;
        bin          = lat / BUCKET_WIDTH;
        n_samples[s] = n_samples[s] + 32'd1;
        sum_cyc[s]   = sum_cyc[s] + {32'd0, lat};
        if (lat < lo_lat[s])
            lo_lat[s] = lat;
        if (lat > hi_lat[s])
            hi_lat[s] = lat;
        if (bin < BUCKET_COUNT)
            hist[s][bin] = hist[s][bin] + 32'd1;
        else
            spill[s] = spill[s] + 32'd1;
    endfunction

    // Apply one input beat to the shadow state and work out its result
    function automatic slot_report_t account_beat(input logic [2:0] m, input logic [3:0] s,
                                                  input logic [63:0] ts, input logic [31:0] lat,
                                                  input logic [3:0] sel);
        slot_report_t r;
        logic [63:0]  span;
        r        = '0;
        r.status = 1'b1;
        if (s < SLOT_COUNT)
        begin
            case (m)
                MODE_START:
                    if (enable_q)
                    begin
                        origin[s] = ts;
                        armed[s]  = 1'b1;
                        r.status  = 1'b0;
                    end
                MODE_END:
                    if (enable_q && armed[s])
                    begin
                        // difference wraps in 64 bits, then saturates to 32
                        span = ts - origin[s];
                        log_sample(s, (span > {32'd0, LAT_SAT}) ? LAT_SAT : span[31:0]);
                        armed[s] = 1'b0;
                        r.status = 1'b0;
                    end
                MODE_RECORD:
                    if (enable_q)
                    begin
                        log_sample(s, lat);
                        r.status = 1'b0;
                    end
                MODE_CLEAR:
                begin
                    // pending mark and stored stamp survive a clear
                    wipe_slot(s);
                    r.status = 1'b0;
                end
                MODE_READ:
                begin
                    r.samples = n_samples[s];
                    r.total   = sum_cyc[s];
                    r.lat_min = lo_lat[s];
                    r.lat_max = hi_lat[s];
                    r.beyond  = spill[s];
                    r.bucket  = (sel < BUCKET_COUNT) ? hist[s][sel] : '0;
                    r.status  = 1'b0;
                end
                default:
                    ;
            endcase
        end
        return r;
    endfunction

    // Follow config writes and beats on both channels
    always @(posedge clk or negedge rst_n)
    begin
        slot_report_t got;
        slot_report_t due;
        if (!rst_n)
        begin
            enable_q = 1'b1;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                origin[s] = '0;
                armed[s]  = 1'b0;
                wipe_slot(s);
            end
            due_reports.delete();
            due_depth <= 0;
        end
        else
        begin
            if (cfg_we)
                enable_q = cfg_data;
            if (in_valid && in_ready)
                due_reports.push_back(account_beat(mode, op_slot, time_stamp, latency_in,
                                                   bucket_select));
            if (out_valid && out_ready)
            begin
                got = '{status, sample_count, cycle_total, latency_min, latency_max,
                        overflow_count, bucket_count};
                if (due_reports.size() == 0)
                begin
                    if (flaw_count < 10)
                        $display("%0t: result beat with nothing outstanding: %p", $realtime, got);
                    flaw_count = flaw_count + 1;
                end
                else
                begin
                    due = due_reports.pop_front();
                    if (got !== due)
                    begin
                        if (flaw_count < 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  want st=%b n=%h sum=%h min=%h max=%h ovf=%h bkt=%h",
                                     due.status, due.samples, due.total, due.lat_min,
                                     due.lat_max, due.beyond, due.bucket);
                            $display("  got  st=%b n=%h sum=%h min=%h max=%h ovf=%h bkt=%h",
                                     got.status, got.samples, got.total, got.lat_min,
                                     got.lat_max, got.beyond, got.bucket);
                        end
                        flaw_count = flaw_count + 1;
                    end
                end
            end
            due_depth <= due_reports.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the latency histogram monitor testbench: clock, reset, stimulus and verdict.
// Depends on lhm_pkg, lhm_checker and the latency_histogram_monitor RTL.
module tb;
    import lhm_pkg::*;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int         HIST_SPAN        = BUCKETS_DEFAULT * BUCKET_CYCLES_DEFAULT;
    localparam int         PHASE_BEATS      = 325;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  mode;
    logic [3:0]  op_slot;
    logic [63:0] time_stamp;
    logic [31:0] latency_in;
    logic [3:0]  bucket_select;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic [31:0] sample_count;
    logic [63:0] cycle_total;
    logic [31:0] latency_min;
    logic [31:0] latency_max;
    logic [31:0] overflow_count;
    logic [31:0] bucket_count;
    int          fail_count;
    int          awaiting;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          idle_plan   [4] = '{0, 62, 0, 13};
    int          stall_plan  [4] = '{0, 0, 62, 13};
    logic        enable_plan [4] = '{1'b1, 1'b1, 1'b0, 1'b1};
    logic [63:0] slot_origin [16];

    latency_histogram_monitor u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .op_slot        (op_slot),
        .time_stamp     (time_stamp),
        .latency_in     (latency_in),
        .bucket_select  (bucket_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .sample_count   (sample_count),
        .cycle_total    (cycle_total),
        .latency_min    (latency_min),
        .latency_max    (latency_max),
        .overflow_count (overflow_count),
        .bucket_count   (bucket_count)
    );

    lhm_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .op_slot        (op_slot),
        .time_stamp     (time_stamp),
        .latency_in     (latency_in),
        .bucket_select  (bucket_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .sample_count   (sample_count),
        .cycle_total    (cycle_total),
        .latency_min    (latency_min),
        .latency_max    (latency_max),
        .overflow_count (overflow_count),
        .bucket_count   (bucket_count),
        .fail_count     (fail_count),
        .awaiting       (awaiting)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one beat, with a random gap in front, and wait for it to be taken
    task automatic send_beat(input logic [2:0] m, input logic [3:0] s, input logic [63:0] ts,
                             input logic [31:0] lat, input logic [3:0] sel);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        op_slot       <= s;
        time_stamp    <= ts;
        latency_in    <= lat;
        bucket_select <= sel;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic drain_results();
        int guard;
        in_valid <= 1'b0;
        @(posedge clk);
        for (guard = 0; guard < 20000 && awaiting != 0; guard++)
            @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Latencies weighted towards the histogram range and its edges
    function automatic logic [31:0] draw_latency();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return 32'($urandom_range(0, HIST_SPAN + 2 * BUCKET_CYCLES_DEFAULT));
        else if (pick < 16)
            return 32'($urandom);
        else if (pick == 16)
            return 32'(HIST_SPAN - 1);
        else if (pick == 17)
            return 32'(HIST_SPAN);
        else if (pick == 18)
            return '0;
        return LAT_SAT;
    endfunction

    // One random beat; starts and ends are mostly paired per slot
    task automatic random_beat();
        int          pick;
        logic [3:0]  s;
        logic [63:0] ts;
        logic [63:0] span;
        pick = $urandom_range(0, 99);
        s    = 4'($urandom);
        ts   = {32'($urandom), 32'($urandom)};
        if (pick < 22)
        begin
            if ($urandom_range(0, 4) == 0)
                ts = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2000));
            slot_origin[s] = ts;
            send_beat(MODE_START, s, ts, 32'($urandom), 4'($urandom));
        end
        else if (pick < 44)
        begin
            if ($urandom_range(0, 6) == 0)
                span = {32'($urandom), 32'($urandom)};
            else
                span = {32'd0, draw_latency()};
            send_beat(MODE_END, s, slot_origin[s] + span, 32'($urandom), 4'($urandom));
        end
        else if (pick < 62)
            send_beat(MODE_RECORD, s, ts, draw_latency(), 4'($urandom));
        else if (pick < 90)
            send_beat(MODE_READ, s, ts, 32'($urandom), 4'($urandom));
        else if (pick < 95)
            send_beat(MODE_CLEAR, s, ts, 32'($urandom), 4'($urandom));
        else
            send_beat(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), s, ts,
                      32'($urandom), 4'($urandom));
    endtask

    // Stimulus and verdict
    initial
    begin
        in_valid      = 1'b0;
        mode          = MODE_START;
        op_slot       = '0;
        time_stamp    = '0;
        latency_in    = '0;
        bucket_select = '0;
        cfg_we        = 1'b0;
        cfg_data      = 1'b0;
        rst_n         = 1'b0;
        for (int s = 0; s < 16; s++)
            slot_origin[s] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bucket edges and extreme latencies
        send_beat(MODE_RECORD, 4'd0, '0, 32'd0, 4'd0);
        send_beat(MODE_RECORD, 4'd0, '0, 32'(HIST_SPAN - 1), 4'd0);
        send_beat(MODE_RECORD, 4'd0, '0, 32'(HIST_SPAN), 4'd0);
        send_beat(MODE_RECORD, 4'd15, '0, LAT_SAT, 4'd0);
        // stamp difference wrapping past the top of 64 bits
        send_beat(MODE_START, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, '0, 4'd0);
        send_beat(MODE_END, 4'd1, 64'h63, '0, 4'd0);
        // difference too long for 32 bits saturates
        send_beat(MODE_START, 4'd2, 64'd0, '0, 4'd0);
        send_beat(MODE_END, 4'd2, 64'h1_0000_0000, '0, 4'd0);
        // end with no start
        send_beat(MODE_END, 4'd3, 64'd5, '0, 4'd0);
        // a second start overwrites the stored stamp
        send_beat(MODE_START, 4'd4, 64'd10, '0, 4'd0);
        send_beat(MODE_START, 4'd4, 64'd50, '0, 4'd0);
        send_beat(MODE_END, 4'd4, 64'd300, '0, 4'd0);
        send_beat(MODE_READ, 4'd0, '0, '0, 4'd0);
        send_beat(MODE_READ, 4'd0, '0, '0, 4'd15);
        send_beat(MODE_READ, 4'd1, '0, '0, 4'd1);
        send_beat(MODE_READ, 4'd2, '0, '0, 4'd15);
        send_beat(MODE_READ, 4'd4, '0, '0, 4'd2);
        send_beat(MODE_READ, 4'd15, '0, '0, 4'd0);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_beat(3'(m), 4'd0, '0, '0, 4'd0);
        send_beat(MODE_CLEAR, 4'd0, '0, '0, 4'd0);
        send_beat(MODE_READ, 4'd0, '0, '0, 4'd0);
        // clear keeps the pending start
        send_beat(MODE_START, 4'd5, 64'd1000, '0, 4'd0);
        send_beat(MODE_CLEAR, 4'd5, '0, '0, 4'd0);
        send_beat(MODE_END, 4'd5, 64'd1234, '0, 4'd0);
        send_beat(MODE_READ, 4'd5, '0, '0, 4'd2);

        // random phases with different idling, stall and enable settings
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            write_enable(enable_plan[p]);
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int i = 0; i < PHASE_BEATS; i++)
                random_beat();
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && awaiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
